// ===== rtl/core/apc_pkg.sv =====
// Alamouti pair combiner: shared widths, pipeline stage types and helpers.
// No dependencies; every module of the block imports this package.
package apc_pkg;

  // Sample and result formats
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 2;
  localparam int OUT_BITS    = SAMPLE_BITS + 2;

  // Internal word widths
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;   // full signed product
  localparam int SQ_BITS     = PROD_BITS - 1;     // square, never negative
  localparam int PAIR_BITS   = PROD_BITS + 1;     // sum of two products
  localparam int SUM_BITS    = PROD_BITS + 2;     // sum of four products
  localparam int RND_BITS    = SUM_BITS - FRAC_BITS;
  localparam int EPAIR_BITS  = PROD_BITS;         // sum of two squares
  localparam int ENERGY_BITS = PROD_BITS + 1;     // sum of four squares

  // sqrt(1/2) as unsigned Q0.16
  localparam int ROOT_BITS   = 16;
  localparam int HALF_ROOT   = 46341;
  localparam int SCALED_BITS = ENERGY_BITS + ROOT_BITS;
  localparam int GAIN_SHIFT  = FRAC_BITS + ROOT_BITS;
  localparam int GQ_BITS     = SCALED_BITS - GAIN_SHIFT;

  // Combiner structure: four output components, four terms each
  localparam int N_SUMS  = 4;
  localparam int N_TERMS = 4;
  localparam int N_IN    = 8;
  localparam int N_WORDS = 5;

  // Component order: sym0_re, sym0_im, sym1_re, sym1_im
  localparam int SYM0_RE = 0;
  localparam int SYM0_IM = 1;
  localparam int SYM1_RE = 2;
  localparam int SYM1_IM = 3;

  // Per component: second term of each pair subtracts / second pair subtracts
  localparam logic [N_SUMS-1:0] PAIR_SUB  = 4'b1010;
  localparam logic [N_SUMS-1:0] FINAL_SUB = 4'b1100;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((N_IN * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((N_WORDS * OUT_BITS + 7) / 8) * 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t rx0_re;
    sample_t rx0_im;
    sample_t rx1_re;
    sample_t rx1_im;
    sample_t ha_re;
    sample_t ha_im;
    sample_t hb_re;
    sample_t hb_im;
  } in_item_t;

  // Stage 1: all products and squares
  typedef struct packed {
    logic [N_SUMS-1:0][N_TERMS-1:0][PROD_BITS-1:0] term;
    logic [N_TERMS-1:0][SQ_BITS-1:0]               sq;
  } prod_stage_t;

  // Stage 2: pairwise sums
  typedef struct packed {
    logic [N_SUMS-1:0][1:0][PAIR_BITS-1:0] pair;
    logic [1:0][EPAIR_BITS-1:0]            epair;
  } pair_stage_t;

  // Stage 3: exact totals
  typedef struct packed {
    logic [N_SUMS-1:0][SUM_BITS-1:0] total;
    logic [ENERGY_BITS-1:0]          energy;
  } sum_stage_t;

  // Stage 4: rounded symbols, scaled energy
  typedef struct packed {
    logic [N_SUMS-1:0][RND_BITS-1:0] q;
    logic [SCALED_BITS-1:0]          scaled;
  } round_stage_t;

  // Stage 5: final result
  typedef struct packed {
    logic [N_SUMS-1:0][OUT_BITS-1:0] sym;
    logic [OUT_BITS-1:0]             gain;
    logic                            clipped;
  } result_t;

  // Full-width signed product
  function automatic logic signed [PROD_BITS-1:0] mul_s(sample_t x, sample_t y);
    logic signed [PROD_BITS-1:0] p;
    p = PROD_BITS'(x) * PROD_BITS'(y);
    return p;
  endfunction

  // Square; the top bit of the signed product is always zero
  function automatic logic [SQ_BITS-1:0] sq_u(sample_t x);
    logic signed [PROD_BITS-1:0] p;
    p = PROD_BITS'(x) * PROD_BITS'(x);
    return p[SQ_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/apc_mult.sv =====
// Alamouti pair combiner, stage 1: the sixteen cross products and four squares.
// Depends on apc_pkg.
module apc_mult import apc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  in_item_t    item,
  output logic        stage_valid,
  output prod_stage_t stage
);

  prod_stage_t stage_next;

  // Terms grouped so each component is (t0 +/- t1) +/- (t2 +/- t3)
  always_comb begin
    stage_next.term[SYM0_RE][0] = mul_s(item.ha_re, item.rx0_re);
    stage_next.term[SYM0_RE][1] = mul_s(item.ha_im, item.rx0_im);
    stage_next.term[SYM0_RE][2] = mul_s(item.hb_re, item.rx1_re);
    stage_next.term[SYM0_RE][3] = mul_s(item.hb_im, item.rx1_im);

    stage_next.term[SYM0_IM][0] = mul_s(item.ha_re, item.rx0_im);
    stage_next.term[SYM0_IM][1] = mul_s(item.ha_im, item.rx0_re);
    stage_next.term[SYM0_IM][2] = mul_s(item.hb_im, item.rx1_re);
    stage_next.term[SYM0_IM][3] = mul_s(item.hb_re, item.rx1_im);

    stage_next.term[SYM1_RE][0] = mul_s(item.hb_re, item.rx0_re);
    stage_next.term[SYM1_RE][1] = mul_s(item.hb_im, item.rx0_im);
    stage_next.term[SYM1_RE][2] = mul_s(item.ha_re, item.rx1_re);
    stage_next.term[SYM1_RE][3] = mul_s(item.ha_im, item.rx1_im);

    stage_next.term[SYM1_IM][0] = mul_s(item.hb_re, item.rx0_im);
    stage_next.term[SYM1_IM][1] = mul_s(item.hb_im, item.rx0_re);
    stage_next.term[SYM1_IM][2] = mul_s(item.ha_im, item.rx1_re);
    stage_next.term[SYM1_IM][3] = mul_s(item.ha_re, item.rx1_im);

    stage_next.sq[0] = sq_u(item.ha_re);
    stage_next.sq[1] = sq_u(item.ha_im);
    stage_next.sq[2] = sq_u(item.hb_re);
    stage_next.sq[3] = sq_u(item.hb_im);
  end

  // Valid and payload advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (en) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

// ===== rtl/core/apc_accum.sv =====
// Alamouti pair combiner, stages 2 and 3: exact adder tree for the four
// symbol components and the channel energy. Depends on apc_pkg.
module apc_accum import apc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  prod_stage_t prod,
  output logic        stage_valid,
  output sum_stage_t  stage
);

  pair_stage_t pair_next;
  pair_stage_t pair;
  logic        pair_valid;
  sum_stage_t  stage_next;

  // Pairwise add/subtract of products
  always_comb begin
    logic signed [PAIR_BITS-1:0] t0, t1, t2, t3;
    for (int k = 0; k < N_SUMS; k++) begin
      t0 = PAIR_BITS'($signed(prod.term[k][0]));
      t1 = PAIR_BITS'($signed(prod.term[k][1]));
      t2 = PAIR_BITS'($signed(prod.term[k][2]));
      t3 = PAIR_BITS'($signed(prod.term[k][3]));
      pair_next.pair[k][0] = PAIR_SUB[k] ? t0 - t1 : t0 + t1;
      pair_next.pair[k][1] = PAIR_SUB[k] ? t2 - t3 : t2 + t3;
    end
    pair_next.epair[0] = EPAIR_BITS'(prod.sq[0]) + EPAIR_BITS'(prod.sq[1]);
    pair_next.epair[1] = EPAIR_BITS'(prod.sq[2]) + EPAIR_BITS'(prod.sq[3]);
  end

  // Combine the two pairs
  always_comb begin
    logic signed [SUM_BITS-1:0] p0, p1;
    for (int k = 0; k < N_SUMS; k++) begin
      p0 = SUM_BITS'($signed(pair.pair[k][0]));
      p1 = SUM_BITS'($signed(pair.pair[k][1]));
      stage_next.total[k] = FINAL_SUB[k] ? p0 - p1 : p0 + p1;
    end
    stage_next.energy = ENERGY_BITS'(pair.epair[0]) + ENERGY_BITS'(pair.epair[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid  <= 1'b0;
      stage_valid <= 1'b0;
    end else if (en) begin
      pair_valid  <= in_valid;
      stage_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair  <= pair_next;
      stage <= stage_next;
    end
  end

endmodule

// ===== rtl/core/apc_scale.sv =====
// Alamouti pair combiner, stages 4 and 5: round half up, gain scaling by
// sqrt(1/2), saturation and the clip flag. Depends on apc_pkg.
module apc_scale import apc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  sum_stage_t sums,
  output logic       res_valid,
  output result_t    res
);

  localparam logic signed [SUM_BITS-1:0] HALF_LSB = SUM_BITS'(1) <<< (FRAC_BITS - 1);

  round_stage_t rnd_next;
  round_stage_t rnd;
  logic         rnd_valid;
  result_t      res_next;

  // Add half an output LSB, floor by arithmetic shift; scale the energy
  always_comb begin
    logic signed [SUM_BITS-1:0] biased;
    logic signed [SUM_BITS-1:0] shifted;
    for (int k = 0; k < N_SUMS; k++) begin
      biased  = $signed(sums.total[k]) + HALF_LSB;
      shifted = biased >>> FRAC_BITS;
      rnd_next.q[k] = shifted[RND_BITS-1:0];
    end
    rnd_next.scaled = SCALED_BITS'(sums.energy) * SCALED_BITS'(HALF_ROOT);
  end

  // Saturate symbols and gain, collect the clip flag
  always_comb begin
    logic [N_SUMS-1:0]  sym_clip;
    logic [GQ_BITS:0]   gain_full;
    logic               gain_clip;
    for (int k = 0; k < N_SUMS; k++) begin
      // fits when every bit above the output sign bit matches it
      sym_clip[k] = !((&rnd.q[k][RND_BITS-1:OUT_BITS-1]) ||
                      !(|rnd.q[k][RND_BITS-1:OUT_BITS-1]));
      if (sym_clip[k]) begin
        res_next.sym[k] = rnd.q[k][RND_BITS-1] ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                               : {1'b0, {(OUT_BITS-1){1'b1}}};
      end else begin
        res_next.sym[k] = rnd.q[k][OUT_BITS-1:0];
      end
    end
    gain_full = {1'b0, rnd.scaled[SCALED_BITS-1:GAIN_SHIFT]}
              + (GQ_BITS+1)'(rnd.scaled[GAIN_SHIFT-1]);
    gain_clip = |gain_full[GQ_BITS:OUT_BITS];
    res_next.gain    = gain_clip ? {OUT_BITS{1'b1}} : gain_full[OUT_BITS-1:0];
    res_next.clipped = (|sym_clip) | gain_clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= in_valid;
      res_valid <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd <= rnd_next;
      res <= res_next;
    end
  end

endmodule

// ===== rtl/core/apc_out_buf.sv =====
// Alamouti pair combiner output register with skid entry; keeps the input
// side ready registered. Depends on apc_pkg.
module apc_out_buf import apc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = !skid_valid;

  // Output register refills from the skid entry first, then from the input
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (in_valid && in_ready && out_valid && !out_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== rtl/core/alamouti_pair_combiner_top.sv =====
// Alamouti 2x1 space-time decoder: one received pair r0, r1 with channel gains
// ha, hb (complex Q1.14) per transfer, giving sym0 = conj(ha)*r0 + hb*conj(r1),
// sym1 = conj(hb)*r0 - ha*conj(r1) as saturated Q3.14, and the shared gain
// (|ha|^2+|hb|^2)*sqrt(1/2) as unsigned Q4.14, rounded half up; clipped (tuser)
// flags any saturation. One pair is taken every cycle while s_tready is high; each
// result passes five arithmetic stages (products, two adder levels, rounding and
// gain multiply, saturation) and then the output register.
// Back-pressure stalls the whole pipeline; a skid entry keeps s_tready registered.
// Depends on apc_pkg, apc_mult, apc_accum, apc_scale and apc_out_buf.
module alamouti_pair_combiner_top import apc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // rx0_re, rx0_im, rx1_re, rx1_im, ha_re, ha_im, hb_re, hb_im (16 bits each)
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // sym0_re, sym0_im, sym1_re, sym1_im, pair_gain (18 bits each), zero pad
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // clipped
  output logic                     m_tuser
);

  logic        en;
  in_item_t    item;
  logic        prod_valid;
  prod_stage_t prod;
  logic        sum_valid;
  sum_stage_t  sums;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  // Unpack input fields, first field in the low bits
  always_comb begin
    item.rx0_re = s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
    item.rx0_im = s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
    item.rx1_re = s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
    item.rx1_im = s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
    item.ha_re  = s_tdata[4*SAMPLE_BITS +: SAMPLE_BITS];
    item.ha_im  = s_tdata[5*SAMPLE_BITS +: SAMPLE_BITS];
    item.hb_re  = s_tdata[6*SAMPLE_BITS +: SAMPLE_BITS];
    item.hb_im  = s_tdata[7*SAMPLE_BITS +: SAMPLE_BITS];
  end

  // Pipeline advances whenever the output buffer can take an item
  assign s_tready = en;

  apc_mult u_mult (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .item        (item),
    .stage_valid (prod_valid),
    .stage       (prod)
  );

  apc_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (prod_valid),
    .prod        (prod),
    .stage_valid (sum_valid),
    .stage       (sums)
  );

  apc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sum_valid),
    .sums      (sums),
    .res_valid (res_valid),
    .res       (res)
  );

  apc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (en),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pack results, first field in the low bits
  assign m_tdata = OUT_DATA_BITS'({out_res.gain,
                                   out_res.sym[SYM1_IM], out_res.sym[SYM1_RE],
                                   out_res.sym[SYM0_IM], out_res.sym[SYM0_RE]});
  assign m_tuser = out_res.clipped;

endmodule
